// File: hw/rtl/dscf_pkg.sv
// Shared types, constants and field layouts for the damped spring chain follower.
package dscf_pkg;

  // Number of chain elements (1 to 64).
  localparam int CHAIN_LENGTH = 16;
  localparam int IDX_W = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;

  // Q16.16 state words and the fraction width of all coefficients.
  localparam int POS_W  = 32;
  localparam int FRAC_W = 16;
  localparam int COORD_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS_GAIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_BASE   = CFG_IDX_W'(1);
  localparam logic [CFG_DATA_W-1:0] STIFFNESS_RESET = 16'd6554;
  localparam logic [CFG_DATA_W-1:0] DAMPING_RESET   = 16'd58982;

  // Stiffness: floor(gain * (i+1) / 20), saturated at 1.0 (65536).
  localparam int STIFF_DIV   = 20;
  localparam int RECIP_SHIFT = 20;
  localparam int STIFF_RECIP = (2**RECIP_SHIFT + STIFF_DIV - 1) / STIFF_DIV;
  localparam int QG_LSB      = RECIP_SHIFT - FRAC_W;
  localparam int QG_W        = $clog2(65535 / STIFF_DIV + 1);
  localparam int K_ONE       = 65536;
  localparam int K_W         = 17;
  localparam int K_ACC_W     = $clog2(65535 * CHAIN_LENGTH / STIFF_DIV + 1);
  localparam int KR_W        = $clog2(STIFF_DIV);

  // Damping: base - round(0.02 * i), as floor((i * 131072 + 50) / 100).
  localparam int DAMP_NUM_STEP = 131072;
  localparam int DAMP_DIV      = 100;
  localparam int DAMP_STEP_INT = DAMP_NUM_STEP / DAMP_DIV;
  localparam int DAMP_STEP_REM = DAMP_NUM_STEP % DAMP_DIV;
  localparam int DAMP_REM_INIT = 50;
  localparam int D_W           = 16;
  localparam int SUB_W =
    $clog2(((CHAIN_LENGTH - 1) * DAMP_NUM_STEP + DAMP_REM_INIT) / DAMP_DIV + 2);
  localparam int DR_W  = $clog2(2 * DAMP_DIV);

  // Shared arithmetic unit.
  localparam int ALU_W   = 34;
  localparam int MUL_B_W = 18;

  typedef enum logic [1:0] {
    ALU_SUB,
    ALU_MUL,
    ALU_ADDSAT
  } alu_op_t;

  typedef struct packed {
    alu_op_t                  op;
    logic signed [ALU_W-1:0]  a;
    logic signed [ALU_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic load;
    logic step;
  } coef_ctl_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
    logic                      active;
  } in_item_t;

  typedef struct packed {
    logic [5:0]                element_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      last;
  } out_item_t;

endpackage

// File: hw/rtl/dscf_alu.sv
// Shared arithmetic unit: subtract, saturating add, and Q16 multiply, result registered.
module dscf_alu (
  input  logic                                clk,
  input  dscf_pkg::alu_req_t                  req,
  output logic signed [dscf_pkg::ALU_W-1:0]   res
);
  import dscf_pkg::*;

  localparam int SUM_W  = ALU_W + 1;
  localparam int PROD_W = ALU_W + MUL_B_W;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  diff;
  logic signed [ALU_W-1:0]  res_next;

  assign prod    = PROD_W'(req.a) * PROD_W'($signed(req.b[MUL_B_W-1:0]));
  assign prod_sh = prod >>> FRAC_W;
  assign sum     = SUM_W'(req.a) + SUM_W'(req.b);
  assign diff    = SUM_W'(req.a) - SUM_W'(req.b);

  always_comb begin
    case (req.op)
      ALU_SUB:    res_next = diff[ALU_W-1:0];
      ALU_MUL:    res_next = prod_sh[ALU_W-1:0];
      ALU_ADDSAT: begin
        if (sum > SAT_HI) begin
          res_next = ALU_W'(SAT_HI);
        end else if (sum < SAT_LO) begin
          res_next = ALU_W'(SAT_LO);
        end else begin
          res_next = sum[ALU_W-1:0];
        end
      end
      default:    res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

// File: hw/rtl/dscf_coef.sv
// Per-element stiffness and damping coefficients, stepped one element at a time.
module dscf_coef (
  input  logic                          clk,
  input  dscf_pkg::coef_ctl_t           ctl,
  input  logic [dscf_pkg::QG_W-1:0]     gain_q,
  input  logic [dscf_pkg::CFG_DATA_W-1:0] gain,
  input  logic [dscf_pkg::CFG_DATA_W-1:0] base,
  output logic [dscf_pkg::K_W-1:0]      k,
  output logic [dscf_pkg::D_W-1:0]      d
);
  import dscf_pkg::*;

  logic [K_ACC_W-1:0] q;
  logic [KR_W-1:0]    r;
  logic [SUB_W-1:0]   sub;
  logic [DR_W-1:0]    srem;
  logic [QG_W-1:0]    gq;
  logic [KR_W-1:0]    gr;
  logic [KR_W-1:0]    gain_r;
  logic [KR_W:0]      r_sum;
  logic               r_carry;
  logic [DR_W-1:0]    s_sum;
  logic               s_carry;

  // Remainder of gain / 20, from the quotient found by the shared unit. The
  // quotient is only on the shared unit's output during the load, so it and
  // the remainder are kept for the later steps.
  assign gain_r  = KR_W'(gain - CFG_DATA_W'({gain_q, 4'b0} + {2'b0, gain_q, 2'b0}));
  assign r_sum   = (KR_W+1)'(r) + (KR_W+1)'(gr);
  assign r_carry = r_sum >= (KR_W+1)'(STIFF_DIV);
  assign s_sum   = srem + DR_W'(DAMP_STEP_REM);
  assign s_carry = s_sum >= DR_W'(DAMP_DIV);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      gq   <= gain_q;
      gr   <= gain_r;
      q    <= K_ACC_W'(gain_q);
      r    <= gain_r;
      sub  <= '0;
      srem <= DR_W'(DAMP_REM_INIT);
    end else if (ctl.step) begin
      q    <= q + K_ACC_W'(gq) + K_ACC_W'(r_carry);
      r    <= r_carry ? KR_W'(r_sum - (KR_W+1)'(STIFF_DIV)) : KR_W'(r_sum);
      sub  <= sub + SUB_W'(DAMP_STEP_INT) + SUB_W'(s_carry);
      srem <= s_carry ? s_sum - DR_W'(DAMP_DIV) : s_sum;
    end
  end

  assign k = (32'(q) > 32'(K_ONE)) ? K_W'(K_ONE) : K_W'(q);
  assign d = (32'(base) >= 32'(sub)) ? D_W'(32'(base) - 32'(sub)) : '0;

endmodule

// File: hw/rtl/damped_spring_chain_follower.sv
// Top level of the damped spring chain follower: sequencer, chain state and ports.
//
//   channel  direction  handshake            payload
//   in       receive    in_valid / in_stall    in_item_t (target point, active)
//   out      send       out_valid / out_stall  out_item_t (one element position)
//   cfg      receive    cfg_write              cfg_index, cfg_data
//
// Each input transfer produces CHAIN_LENGTH output transfers, one per element,
// in element order, with last set on the final one.
// An active item runs, per element, the spring step on each axis, sends the
// element and damps its velocities; an inactive item instead snaps each element
// to the target before sending and damping it. The next transfer is taken in idle.
// Steps run one after another on the single shared arithmetic unit, which does every
// subtract, add and multiply of the spring update and the damping in turn.
// in_stall is high from the accepted transfer until the last element has been
// damped. The output register holds one result; the sequencer waits only if a
// new result is ready while the previous one has not yet been taken.
// Reset (synchronous, active high) clears the chain positions and velocities,
// restores the register defaults and returns the sequencer to idle.
module damped_spring_chain_follower (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  dscf_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output dscf_pkg::out_item_t                  out_data,
  input  logic                                 cfg_write,
  input  logic [dscf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dscf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dscf_pkg::*;

  // Sequencer states. Each spring step (subtract, multiply, velocity add, position
  // add, write back) runs once per axis, or for an inactive item a snap instead,
  // then the result is sent, then the three velocities are damped.
  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_RECIP = 12'b0000_0000_0010,
    S_COEF  = 12'b0000_0000_0100,
    S_SNAP  = 12'b0000_0000_1000,
    S_SUB   = 12'b0000_0001_0000,
    S_MULK  = 12'b0000_0010_0000,
    S_VEL   = 12'b0000_0100_0000,
    S_POS   = 12'b0000_1000_0000,
    S_PWR   = 12'b0001_0000_0000,
    S_OUT   = 12'b0010_0000_0000,
    S_DMUL  = 12'b0100_0000_0000,
    S_DWR   = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  state_t state;
  state_t state_next;
  axis_t  ax;
  axis_t  ax_next;
  logic [IDX_W-1:0] elem;

  logic [CFG_DATA_W-1:0] stiffness_gain;
  logic [CFG_DATA_W-1:0] damping_base;

  in_item_t tgt;

  // Pull point of the current element: the target for element zero, then the
  // freshly updated position of the element before.
  logic signed [POS_W-1:0] prev_x;
  logic signed [POS_W-1:0] prev_y;
  logic signed [POS_W-1:0] prev_z;

  logic signed [POS_W-1:0] pos_x_mem [CHAIN_LENGTH];
  logic signed [POS_W-1:0] pos_y_mem [CHAIN_LENGTH];
  logic signed [POS_W-1:0] pos_z_mem [CHAIN_LENGTH];
  logic signed [POS_W-1:0] vel_x_mem [CHAIN_LENGTH];
  logic signed [POS_W-1:0] vel_y_mem [CHAIN_LENGTH];
  logic signed [POS_W-1:0] vel_z_mem [CHAIN_LENGTH];

  logic signed [POS_W-1:0] pos_cur;
  logic signed [POS_W-1:0] vel_cur;
  logic signed [POS_W-1:0] pull_cur;

  alu_req_t                alu_req;
  logic signed [ALU_W-1:0] alu_res;
  coef_ctl_t               coef_ctl;
  logic [K_W-1:0]          k;
  logic [D_W-1:0]          d;

  logic last_elem;
  logic out_free;

  assign last_elem = (elem == IDX_W'(CHAIN_LENGTH - 1));
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  dscf_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .res (alu_res)
  );

  dscf_coef u_coef (
    .clk    (clk),
    .ctl    (coef_ctl),
    .gain_q (alu_res[QG_LSB + QG_W - 1:QG_LSB]),
    .gain   (stiffness_gain),
    .base   (damping_base),
    .k      (k),
    .d      (d)
  );

  // Operands of the current axis.
  always_comb begin
    case (ax)
      AX_X: begin
        pos_cur  = pos_x_mem[elem];
        vel_cur  = vel_x_mem[elem];
        pull_cur = prev_x;
      end
      AX_Y: begin
        pos_cur  = pos_y_mem[elem];
        vel_cur  = vel_y_mem[elem];
        pull_cur = prev_y;
      end
      default: begin
        pos_cur  = pos_z_mem[elem];
        vel_cur  = vel_z_mem[elem];
        pull_cur = prev_z;
      end
    endcase
  end

  always_comb begin
    case (ax)
      AX_X:    ax_next = AX_Y;
      AX_Y:    ax_next = AX_Z;
      default: ax_next = AX_X;
    endcase
  end

  // Requests to the shared unit. The multiply and both add steps use the result
  // registered by the step before it.
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state)
      S_RECIP: begin
        // gain / 20 as gain * ceil(2^20 / 20) >> 20; exact for 16-bit gains.
        alu_req.op = ALU_MUL;
        alu_req.a  = ALU_W'(stiffness_gain);
        alu_req.b  = ALU_W'(STIFF_RECIP);
      end
      S_SUB: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(pull_cur);
        alu_req.b  = ALU_W'(pos_cur);
      end
      S_MULK: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = alu_res;
        alu_req.b  = ALU_W'(k);
      end
      S_VEL: begin
        alu_req.op = ALU_ADDSAT;
        alu_req.a  = ALU_W'(vel_cur);
        alu_req.b  = alu_res;
      end
      S_POS: begin
        alu_req.op = ALU_ADDSAT;
        alu_req.a  = ALU_W'(pos_cur);
        alu_req.b  = alu_res;
      end
      S_DMUL: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = ALU_W'(vel_cur);
        alu_req.b  = ALU_W'(d);
      end
      default: begin
        alu_req.op = ALU_SUB;
      end
    endcase
  end

  always_comb begin
    coef_ctl.load = (state == S_COEF);
    coef_ctl.step = (state == S_DWR) && (ax == AX_Z) && !last_elem;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  state_next = in_valid ? S_RECIP : S_IDLE;
      S_RECIP: state_next = S_COEF;
      S_COEF:  state_next = tgt.active ? S_SUB : S_SNAP;
      S_SNAP:  state_next = S_OUT;
      S_SUB:   state_next = S_MULK;
      S_MULK:  state_next = S_VEL;
      S_VEL:   state_next = S_POS;
      S_POS:   state_next = S_PWR;
      S_PWR:   state_next = (ax == AX_Z) ? S_OUT : S_SUB;
      S_OUT:   state_next = out_free ? S_DMUL : S_OUT;
      S_DMUL:  state_next = S_DWR;
      S_DWR: begin
        if (ax != AX_Z) begin
          state_next = S_DMUL;
        end else if (last_elem) begin
          state_next = S_IDLE;
        end else begin
          state_next = tgt.active ? S_SUB : S_SNAP;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ax             <= AX_X;
      elem           <= '0;
      out_valid      <= 1'b0;
      stiffness_gain <= STIFFNESS_RESET;
      damping_base   <= DAMPING_RESET;
      for (int i = 0; i < CHAIN_LENGTH; i++) begin
        pos_x_mem[i] <= '0;
        pos_y_mem[i] <= '0;
        pos_z_mem[i] <= '0;
        vel_x_mem[i] <= '0;
        vel_y_mem[i] <= '0;
        vel_z_mem[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          REG_STIFFNESS_GAIN: stiffness_gain <= cfg_data;
          REG_DAMPING_BASE:   damping_base   <= cfg_data;
          default: ;
        endcase
      end

      // A new result loads the output register; otherwise it empties once taken.
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tgt    <= in_data;
            prev_x <= {in_data.target_x, FRAC_W'(0)};
            prev_y <= {in_data.target_y, FRAC_W'(0)};
            prev_z <= {in_data.target_z, FRAC_W'(0)};
            elem   <= '0;
            ax     <= AX_X;
          end
        end
        S_SNAP: begin
          pos_x_mem[elem] <= {tgt.target_x, FRAC_W'(0)};
          pos_y_mem[elem] <= {tgt.target_y, FRAC_W'(0)};
          pos_z_mem[elem] <= {tgt.target_z, FRAC_W'(0)};
        end
        S_POS: begin
          case (ax)
            AX_X:    vel_x_mem[elem] <= alu_res[POS_W-1:0];
            AX_Y:    vel_y_mem[elem] <= alu_res[POS_W-1:0];
            default: vel_z_mem[elem] <= alu_res[POS_W-1:0];
          endcase
        end
        S_PWR: begin
          case (ax)
            AX_X:    pos_x_mem[elem] <= alu_res[POS_W-1:0];
            AX_Y:    pos_y_mem[elem] <= alu_res[POS_W-1:0];
            default: pos_z_mem[elem] <= alu_res[POS_W-1:0];
          endcase
          ax <= ax_next;
        end
        S_OUT: begin
          if (out_free) begin
            out_data.element_index <= 6'(elem);
            out_data.pos_x         <= pos_x_mem[elem][POS_W-1:FRAC_W];
            out_data.pos_y         <= pos_y_mem[elem][POS_W-1:FRAC_W];
            out_data.pos_z         <= pos_z_mem[elem][POS_W-1:FRAC_W];
            out_data.last          <= last_elem;
            prev_x                 <= pos_x_mem[elem];
            prev_y                 <= pos_y_mem[elem];
            prev_z                 <= pos_z_mem[elem];
            ax                     <= AX_X;
          end
        end
        S_DWR: begin
          // |v * d / 65536| never exceeds |v|, so no saturation is needed.
          case (ax)
            AX_X:    vel_x_mem[elem] <= alu_res[POS_W-1:0];
            AX_Y:    vel_y_mem[elem] <= alu_res[POS_W-1:0];
            default: vel_z_mem[elem] <= alu_res[POS_W-1:0];
          endcase
          ax <= ax_next;
          if (ax == AX_Z && !last_elem) begin
            elem <= elem + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
